[sv/qrc_pkg.sv]
// ----------------------------------------------------------------------------
// Quadrotor rate controller package
// Types, fixed-point constants and small helpers for the rate controller.
// ----------------------------------------------------------------------------
package qrc_pkg;

   localparam int RATE_WIDTH_DEF = 24;
   localparam int THRUST_W       = 20;
   localparam int SPEED_W        = 17;
   localparam int ACC_W          = 64;
   localparam int DIGIT          = 4;
   localparam int NDIG           = 9;
   localparam int BW             = DIGIT * NDIG;

   localparam logic [SPEED_W-1:0] HOVER_SPEED = 17'd46415;
   localparam logic [SPEED_W-1:0] SPEED_MIN   = 17'd5120;
   localparam logic [SPEED_W-1:0] SPEED_MAX   = 17'd76800;

   localparam logic [BW-1:0] INERTIA_XY    = 36'd64220;
   localparam logic [BW-1:0] INERTIA_Z     = 36'd119697;
   localparam logic [BW-1:0] INERTIA_ZX    = 36'd55477;
   localparam logic [BW-1:0] MIX_THRUST    = 36'd2144628;
   localparam logic [BW-1:0] MIX_ROLLPITCH = 36'd14794798;
   localparam logic [BW-1:0] MIX_YAW       = 36'd198019802;

   localparam logic signed [ACC_W-1:0] USQ_MIN = 64'sd26214400;
   localparam logic signed [ACC_W-1:0] USQ_MAX = 64'sd5898240000;
   localparam logic signed [ACC_W-1:0] LIM_31  = 64'sd2147483648;
   localparam logic signed [ACC_W-1:0] LIM_40  = 64'sd1099511627776;
   localparam logic signed [ACC_W-1:0] LIM_41  = 64'sd2199023255552;
   localparam logic signed [ACC_W-1:0] LIM_46  = 64'sd70368744177664;
   localparam logic signed [ACC_W-1:0] I32_MIN = -64'sd2147483648;
   localparam logic signed [ACC_W-1:0] I32_MAX = 64'sd2147483647;

   localparam logic [2:0] REG_GAIN_PROP     = 3'd0;
   localparam logic [2:0] REG_GAIN_INTEGRAL = 3'd1;
   localparam logic [2:0] REG_GAIN_DERIV    = 3'd2;
   localparam logic [2:0] REG_TIME_STEP     = 3'd3;
   localparam logic [2:0] REG_TIME_RECIP    = 3'd4;
   localparam logic [2:0] REG_FILTER_WEIGHT = 3'd5;
   localparam logic [2:0] REG_SLEW_STEP     = 3'd6;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_MUL,
      ST_POST,
      ST_SQRT,
      ST_SLEW,
      ST_DONE
   } state_type;

   typedef enum logic [4:0] {
      OP_FILT,
      OP_INTEG,
      OP_DIFF,
      OP_PROP,
      OP_INTG,
      OP_DERV,
      OP_CX,
      OP_CXK,
      OP_TX,
      OP_CY,
      OP_CYK,
      OP_TY,
      OP_TZ,
      OP_MT,
      OP_MX,
      OP_MY,
      OP_MZ
   } op_type;

   function automatic logic signed [ACC_W-1:0] clamp64(input logic signed [ACC_W-1:0] x,
                                                       input logic signed [ACC_W-1:0] lo,
                                                       input logic signed [ACC_W-1:0] hi);
      if (x < lo) begin
         return lo;
      end else if (x > hi) begin
         return hi;
      end
      return x;
   endfunction

   // Torque sign in the inverse mixer for a given motor and axis.
   function automatic logic mix_neg(input logic [1:0] mot, input logic [1:0] axis);
      logic neg;
      case (axis)
         2'd0:    neg = (mot == 2'd1) || (mot == 2'd2);
         2'd1:    neg = (mot == 2'd0) || (mot == 2'd1);
         default: neg = (mot == 2'd1) || (mot == 2'd3);
      endcase
      return neg;
   endfunction

endpackage

[sv/quadrotor_rate_controller.sv]
// ----------------------------------------------------------------------------
// Quadrotor rate controller
// Gyro filter, body-rate PID, inertia torque and inverse mixer on one shared
// digit-serial multiply-accumulate unit, then square root and slew limit.
// ----------------------------------------------------------------------------
//  Channel  Ports                  Direction  Contents
//  req      req_valid/req_ready    in         gyro rates, reference rates, thrust
//  rsp      rsp_valid/rsp_ready    out        four motor speed commands
//  csr      psel/penable/pwrite    in         seven gain and timing registers
//
//  An item takes 41 multiplies on the shared 4-bit-digit MAC, plus a square
//  root and a slew-limit step per motor.
//  Reset is synchronous and restores registers, filter, integral and speeds.
//  A finished beat waits in the output register; the next item is accepted
//  meanwhile and stalls only at its end if that beat is still not taken.
// ----------------------------------------------------------------------------
module quadrotor_rate_controller #(
   parameter int RATE_WIDTH = qrc_pkg::RATE_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [RATE_WIDTH-1:0]        req_gyro_x,
   input  logic signed [RATE_WIDTH-1:0]        req_gyro_y,
   input  logic signed [RATE_WIDTH-1:0]        req_gyro_z,
   input  logic signed [RATE_WIDTH-1:0]        req_ref_rate_x,
   input  logic signed [RATE_WIDTH-1:0]        req_ref_rate_y,
   input  logic signed [RATE_WIDTH-1:0]        req_ref_rate_z,
   input  logic [qrc_pkg::THRUST_W-1:0]        req_ref_thrust,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [qrc_pkg::SPEED_W-1:0]         rsp_motor_speed_0,
   output logic [qrc_pkg::SPEED_W-1:0]         rsp_motor_speed_1,
   output logic [qrc_pkg::SPEED_W-1:0]         rsp_motor_speed_2,
   output logic [qrc_pkg::SPEED_W-1:0]         rsp_motor_speed_3,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [4:0]                          paddr,
   input  logic [31:0]                         pwdata,
   output logic [31:0]                         prdata,
   output logic                                pready
);
   import qrc_pkg::*;

   localparam int W  = RATE_WIDTH;
   localparam int EW = RATE_WIDTH + 1;
   localparam logic signed [ACC_W-1:0] RMAX = ACC_W'((64'sd1 <<< (W - 1)) - 1);
   localparam logic signed [ACC_W-1:0] RMIN = -RMAX - 64'sd1;

   state_type state_ff, state_in;
   op_type    op_ff, op_in;

   logic [15:0] kp_ff, ki_ff, kd_ff, ts_ff, recip_ff;
   logic [16:0] w_ff, slew_ff;
   logic [16:0] w_eff;

   logic signed [W-1:0]  gyro_ff [3], gyro_in [3];
   logic signed [W-1:0]  ref_ff [3], ref_in [3];
   logic [THRUST_W-1:0]  thrust_ff, thrust_in;

   logic signed [W-1:0]  f_ff [3], f_in [3];
   logic signed [31:0]   integ_ff [3], integ_in [3];
   logic signed [EW-1:0] pe_ff [3], pe_in [3];
   logic [SPEED_W-1:0]   speed_ff [4], speed_in [4];
   logic signed [41:0]   pid_ff [3], pid_in [3];
   logic signed [32:0]   tq_ff [3], tq_in [3];
   logic signed [EW-1:0] e_ff, e_in;
   logic signed [47:0]   tmp_ff, tmp_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in, a_ff, a_in;
   logic [BW-1:0]        b_ff, b_in;
   logic [4:0]           cnt_ff, cnt_in;
   logic [1:0]           ax_ff, ax_in, mot_ff, mot_in;
   logic [33:0]          rad_ff, rad_in;
   logic [18:0]          rem_ff, rem_in;
   logic [SPEED_W-1:0]   root_ff, root_in;
   logic [SPEED_W-1:0]   out_ff [4], out_in [4];
   logic                 rsp_valid_ff, rsp_valid_in;

   logic                    accept, wr_en, out_free, last_digit, sqrt_ge;
   logic [2:0]              idx;
   logic signed [DIGIT:0]   sd;
   logic signed [ACC_W+DIGIT:0] prod;
   logic signed [ACC_W-1:0] acc_sh16, acc_sh20, acc_sh28, fn;
   logic [20:0]             rem_sh, trial;
   logic [17:0]             slew_hi;
   logic signed [18:0]      slew_lo;
   logic [SPEED_W-1:0]      slew_res;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign idx       = paddr[4:2];
   assign wr_en     = psel && penable && pwrite && pready;
   assign pready    = 1'b1;
   assign w_eff     = (w_ff[16] && (w_ff[15:0] != 16'd0)) ? 17'd65536 : w_ff;

   assign last_digit = (cnt_ff == 5'(NDIG - 1));
   assign sd         = {last_digit & b_ff[DIGIT-1], b_ff[DIGIT-1:0]};
   assign prod       = a_ff * sd;
   assign acc_sh16   = acc_ff >>> 16;
   assign acc_sh20   = acc_ff >>> 20;
   assign acc_sh28   = acc_ff >>> 28;
   assign fn         = clamp64(acc_sh16, RMIN, RMAX);

   assign rem_sh  = {rem_ff, rad_ff[33:32]};
   assign trial   = {2'b00, root_ff, 2'b01};
   assign sqrt_ge = (rem_sh >= trial);

   assign slew_hi  = {1'b0, speed_ff[mot_ff]} + {1'b0, slew_ff};
   assign slew_lo  = $signed({2'b00, speed_ff[mot_ff]}) - $signed({2'b00, slew_ff});
   assign slew_res = ({1'b0, root_ff} > slew_hi) ? SPEED_W'(slew_hi) :
                     ($signed({2'b00, root_ff}) < slew_lo) ? SPEED_W'(slew_lo) : root_ff;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_motor_speed_0 = out_ff[0];
   assign rsp_motor_speed_1 = out_ff[1];
   assign rsp_motor_speed_2 = out_ff[2];
   assign rsp_motor_speed_3 = out_ff[3];

   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff    <= 16'd7680;
         ki_ff    <= 16'd2048;
         kd_ff    <= 16'd0;
         ts_ff    <= 16'd655;
         recip_ff <= 16'd100;
         w_ff     <= 17'd6554;
         slew_ff  <= 17'd10240;
      end else if (wr_en) begin
         unique case (idx)
            REG_GAIN_PROP:     kp_ff    <= pwdata[15:0];
            REG_GAIN_INTEGRAL: ki_ff    <= pwdata[15:0];
            REG_GAIN_DERIV:    kd_ff    <= pwdata[15:0];
            REG_TIME_STEP:     ts_ff    <= pwdata[15:0];
            REG_TIME_RECIP:    recip_ff <= pwdata[15:0];
            REG_FILTER_WEIGHT: w_ff     <= pwdata[16:0];
            REG_SLEW_STEP:     slew_ff  <= pwdata[16:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_GAIN_PROP:     prdata = 32'(kp_ff);
         REG_GAIN_INTEGRAL: prdata = 32'(ki_ff);
         REG_GAIN_DERIV:    prdata = 32'(kd_ff);
         REG_TIME_STEP:     prdata = 32'(ts_ff);
         REG_TIME_RECIP:    prdata = 32'(recip_ff);
         REG_FILTER_WEIGHT: prdata = 32'(w_ff);
         REG_SLEW_STEP:     prdata = 32'(slew_ff);
         default:           prdata = 32'd0;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (accept) state_in = ST_LOAD;
         ST_LOAD: state_in = ST_MUL;
         ST_MUL:  if (last_digit) state_in = ST_POST;
         ST_POST: state_in = (op_ff == OP_MZ) ? ST_SQRT : ST_LOAD;
         ST_SQRT: if (cnt_ff == 5'(SPEED_W - 1)) state_in = ST_SLEW;
         ST_SLEW: state_in = (mot_ff == 2'd3) ? ST_DONE : ST_LOAD;
         ST_DONE: if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      gyro_in      = gyro_ff;
      ref_in       = ref_ff;
      thrust_in    = thrust_ff;
      f_in         = f_ff;
      integ_in     = integ_ff;
      pe_in        = pe_ff;
      speed_in     = speed_ff;
      pid_in       = pid_ff;
      tq_in        = tq_ff;
      e_in         = e_ff;
      tmp_in       = tmp_ff;
      acc_in       = acc_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      cnt_in       = cnt_ff;
      ax_in        = ax_ff;
      mot_in       = mot_ff;
      op_in        = op_ff;
      rad_in       = rad_ff;
      rem_in       = rem_ff;
      root_in      = root_ff;
      out_in       = out_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               gyro_in   = '{req_gyro_x, req_gyro_y, req_gyro_z};
               ref_in    = '{req_ref_rate_x, req_ref_rate_y, req_ref_rate_z};
               thrust_in = req_ref_thrust;
               op_in     = OP_FILT;
               ax_in     = 2'd0;
               mot_in    = 2'd0;
            end
         end
         ST_LOAD: begin
            cnt_in = 5'd0;
            acc_in = '0;
            unique case (op_ff)
               OP_FILT: begin
                  a_in   = ACC_W'(gyro_ff[ax_ff]) - ACC_W'(f_ff[ax_ff]);
                  b_in   = BW'(w_eff);
                  acc_in = (ACC_W'(f_ff[ax_ff]) <<< 16) + 64'sd32768;
               end
               OP_INTEG: begin
                  a_in = ACC_W'(e_ff);
                  b_in = BW'(ts_ff);
               end
               OP_DIFF: begin
                  a_in = ACC_W'(e_ff) - ACC_W'(pe_ff[ax_ff]);
                  b_in = BW'(recip_ff);
               end
               OP_PROP: begin
                  a_in = ACC_W'(e_ff);
                  b_in = BW'(kp_ff);
               end
               OP_INTG: begin
                  a_in   = ACC_W'(integ_ff[ax_ff]);
                  b_in   = BW'(ki_ff);
                  acc_in = acc_ff;
               end
               OP_DERV: begin
                  a_in   = ACC_W'(tmp_ff);
                  b_in   = BW'(kd_ff);
                  acc_in = acc_ff;
               end
               OP_CX: begin
                  a_in = ACC_W'(f_ff[1]);
                  b_in = BW'(f_ff[2]);
               end
               OP_CY: begin
                  a_in = ACC_W'(f_ff[2]);
                  b_in = BW'(f_ff[0]);
               end
               OP_CXK, OP_CYK: begin
                  a_in = ACC_W'(tmp_ff);
                  b_in = INERTIA_ZX;
               end
               OP_TX: begin
                  a_in = ACC_W'(pid_ff[0]);
                  b_in = INERTIA_XY;
               end
               OP_TY: begin
                  a_in = ACC_W'(pid_ff[1]);
                  b_in = INERTIA_XY;
               end
               OP_TZ: begin
                  a_in = ACC_W'(pid_ff[2]);
                  b_in = INERTIA_Z;
               end
               OP_MT: begin
                  a_in = ACC_W'(thrust_ff) <<< 12;
                  b_in = MIX_THRUST;
               end
               OP_MX: begin
                  a_in   = mix_neg(mot_ff, 2'd0) ? -ACC_W'(tq_ff[0]) : ACC_W'(tq_ff[0]);
                  b_in   = MIX_ROLLPITCH;
                  acc_in = acc_ff;
               end
               OP_MY: begin
                  a_in   = mix_neg(mot_ff, 2'd1) ? -ACC_W'(tq_ff[1]) : ACC_W'(tq_ff[1]);
                  b_in   = MIX_ROLLPITCH;
                  acc_in = acc_ff;
               end
               default: begin
                  a_in   = mix_neg(mot_ff, 2'd2) ? -ACC_W'(tq_ff[2]) : ACC_W'(tq_ff[2]);
                  b_in   = MIX_YAW;
                  acc_in = acc_ff;
               end
            endcase
         end
         ST_MUL: begin
            acc_in = acc_ff + ACC_W'(prod);
            a_in   = a_ff <<< DIGIT;
            b_in   = b_ff >> DIGIT;
            cnt_in = cnt_ff + 5'd1;
         end
         ST_POST: begin
            unique case (op_ff)
               OP_FILT: begin
                  f_in[ax_ff] = W'(fn);
                  e_in        = EW'(ref_ff[ax_ff]) - EW'(fn);
                  op_in       = OP_INTEG;
               end
               OP_INTEG: begin
                  integ_in[ax_ff] = 32'(clamp64(ACC_W'(integ_ff[ax_ff]) + acc_sh16,
                                                I32_MIN, I32_MAX));
                  op_in = OP_DIFF;
               end
               OP_DIFF: begin
                  tmp_in       = 48'(clamp64(acc_ff, -LIM_41, LIM_41));
                  pe_in[ax_ff] = e_ff;
                  op_in        = OP_PROP;
               end
               OP_PROP: op_in = OP_INTG;
               OP_INTG: op_in = OP_DERV;
               OP_DERV: begin
                  pid_in[ax_ff] = 42'(clamp64(acc_ff, -LIM_40, LIM_40));
                  if (ax_ff == 2'd2) begin
                     op_in = OP_CX;
                  end else begin
                     ax_in = ax_ff + 2'd1;
                     op_in = OP_FILT;
                  end
               end
               OP_CX: begin
                  tmp_in = 48'(clamp64(acc_ff, -LIM_46, LIM_46));
                  op_in  = OP_CXK;
               end
               OP_CXK: begin
                  tmp_in = 48'(acc_sh28);
                  op_in  = OP_TX;
               end
               OP_TX: begin
                  tq_in[0] = 33'(clamp64(ACC_W'(tmp_ff) + acc_sh20, -LIM_31, LIM_31));
                  op_in    = OP_CY;
               end
               OP_CY: begin
                  tmp_in = 48'(clamp64(acc_ff, -LIM_46, LIM_46));
                  op_in  = OP_CYK;
               end
               OP_CYK: begin
                  tmp_in = 48'(-acc_sh28);
                  op_in  = OP_TY;
               end
               OP_TY: begin
                  tq_in[1] = 33'(clamp64(ACC_W'(tmp_ff) + acc_sh20, -LIM_31, LIM_31));
                  op_in    = OP_TZ;
               end
               OP_TZ: begin
                  tq_in[2] = 33'(clamp64(acc_sh20, -LIM_31, LIM_31));
                  op_in    = OP_MT;
                  mot_in   = 2'd0;
               end
               OP_MT: op_in = OP_MX;
               OP_MX: op_in = OP_MY;
               OP_MY: op_in = OP_MZ;
               default: begin
                  rad_in  = 34'(clamp64(acc_sh20, USQ_MIN, USQ_MAX));
                  rem_in  = '0;
                  root_in = '0;
                  cnt_in  = 5'd0;
               end
            endcase
         end
         ST_SQRT: begin
            rem_in  = sqrt_ge ? 19'(rem_sh - trial) : 19'(rem_sh);
            root_in = {root_ff[SPEED_W-2:0], sqrt_ge};
            rad_in  = rad_ff << 2;
            cnt_in  = cnt_ff + 5'd1;
         end
         ST_SLEW: begin
            speed_in[mot_ff] = slew_res;
            if (mot_ff != 2'd3) begin
               mot_in = mot_ff + 2'd1;
               op_in  = OP_MT;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               out_in       = speed_ff;
               rsp_valid_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         op_ff        <= OP_FILT;
         cnt_ff       <= 5'd0;
         ax_ff        <= 2'd0;
         mot_ff       <= 2'd0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            f_ff[i]     <= '0;
            integ_ff[i] <= '0;
            pe_ff[i]    <= '0;
         end
         for (int i = 0; i < 4; i++) begin
            speed_ff[i] <= HOVER_SPEED;
         end
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         cnt_ff       <= cnt_in;
         ax_ff        <= ax_in;
         mot_ff       <= mot_in;
         rsp_valid_ff <= rsp_valid_in;
         f_ff         <= f_in;
         integ_ff     <= integ_in;
         pe_ff        <= pe_in;
         speed_ff     <= speed_in;
      end
   end

   always_ff @(posedge clock) begin
      gyro_ff   <= gyro_in;
      ref_ff    <= ref_in;
      thrust_ff <= thrust_in;
      pid_ff    <= pid_in;
      tq_ff     <= tq_in;
      e_ff      <= e_in;
      tmp_ff    <= tmp_in;
      acc_ff    <= acc_in;
      a_ff      <= a_in;
      b_ff      <= b_in;
      rad_ff    <= rad_in;
      rem_ff    <= rem_in;
      root_ff   <= root_in;
      out_ff    <= out_in;
   end

   a_speed_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_motor_speed_0 >= SPEED_MIN) && (rsp_motor_speed_0 <= SPEED_MAX)
                 && (rsp_motor_speed_3 >= SPEED_MIN) && (rsp_motor_speed_3 <= SPEED_MAX))
      else $error("Motor speed command out of range.");

   a_digit_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL) |-> (cnt_ff < 5'(NDIG)))
      else $error("Multiplier digit count overran.");

   a_start: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_LOAD) && (op_ff == OP_FILT) && (ax_ff == 2'd0))
      else $error("Accepted beat did not start the filter step.");

   a_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) && out_free |=> rsp_valid
         && (rsp_motor_speed_0 == $past(speed_ff[0]))
         && (rsp_motor_speed_3 == $past(speed_ff[3])))
      else $error("Result beat does not match the stored motor speeds.");

endmodule
